FILE: hw/rtl/wla_pkg.sv
package wla_pkg;

    localparam int COORD_BITS = 24;
    localparam int LOOK_W     = 24;
    localparam int WIN_W      = 10;
    localparam int PIDX_W     = 12;
    localparam int CFG_IDX_W  = 1;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DSQ_W  = PROD_W + 1;
    localparam int ROOT_W = (DSQ_W + 1) / 2;
    localparam int CUM_W  = ((ROOT_W > LOOK_W) ? ROOT_W : LOOK_W) + 1;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'd1;

    localparam logic [LOOK_W-1:0] LOOK_RESET = 24'd2048;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 10'd100;

    typedef struct packed {
        logic [1:0]                   kind;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [PIDX_W-1:0]            point_index;
        logic                         valid_res;
        logic                         last;
        logic                         truncated;
    } res_t;

endpackage

FILE: hw/rtl/wla_ram.sv
module wla_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/wla_isqrt.sv
module wla_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [wla_pkg::DSQ_W-1:0]  value,
    output logic                       done,
    output logic [wla_pkg::ROOT_W-1:0] root
);

    localparam int ROOT_W = wla_pkg::ROOT_W;
    localparam int PAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int STEP_W = $clog2(ROOT_W + 1);

    typedef enum logic {
        SQ_IDLE,
        SQ_RUN
    } sq_state_t;

    sq_state_t         state_reg;
    logic [PAD_W-1:0]  val_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    assign rem_sh = {rem_reg[REM_W-3:0], val_reg[PAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                SQ_IDLE:
                begin
                    if (start)
                    begin
                        val_reg   <= PAD_W'(value);
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        step_reg  <= STEP_W'(ROOT_W);
                        state_reg <= SQ_RUN;
                    end
                end
                SQ_RUN:
                begin
                    val_reg <= {val_reg[PAD_W-3:0], 2'b00};
                    if (fits)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == STEP_W'(1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= SQ_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= SQ_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: hw/rtl/waypoint_lookahead_window.sv
// channel  dir  handshake              payload
// cmd      in   cmd_valid / cmd_stall  wla_pkg::cmd_t (kind, coord_x, coord_y)
// res      out  res_valid / res_stall  wla_pkg::res_t (point, index, flags)
// cfg      in   cfg_wen                cfg_index, cfg_data
//
// append and clear are handled in the idle state; a query is paced by the one shared 25x25
// multiplier, used for dx and then dy of each searched waypoint and walked segment, and by
// the square root unit that consumes two radicand bits per cycle on each walked segment.
// reset empties the path, zeroes the search start and loads the register defaults.
// cmd_stall is high while a query is in progress; a held res beat stalls the walk only
// when a second beat is ready.
module waypoint_lookahead_window #(
    parameter int PATH_DEPTH = 4096,
    parameter int MAX_CHUNK  = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  wla_pkg::cmd_t                   cmd,
    output logic                            res_valid,
    input  logic                            res_stall,
    output wla_pkg::res_t                   res,
    input  logic                            cfg_wen,
    input  logic [wla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wla_pkg::LOOK_W-1:0]      cfg_data
);

    localparam int CB     = wla_pkg::COORD_BITS;
    localparam int DIFF_W = wla_pkg::DIFF_W;
    localparam int PROD_W = wla_pkg::PROD_W;
    localparam int DSQ_W  = wla_pkg::DSQ_W;
    localparam int CUM_W  = wla_pkg::CUM_W;
    localparam int LOOK_W = wla_pkg::LOOK_W;
    localparam int WIN_W  = wla_pkg::WIN_W;
    localparam int PIDX_W = wla_pkg::PIDX_W;
    localparam int IDX_W  = $clog2(PATH_DEPTH);
    localparam int CNT_W  = $clog2(PATH_DEPTH + 1);
    localparam int SUM_W  = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
    localparam int N_W    = $clog2(MAX_CHUNK + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_WALK_START,
        ST_WALK_CUR,
        ST_WALK_CHK,
        ST_WALK_RD,
        ST_WALK_SQRT,
        ST_WALK_ACC,
        ST_EMIT,
        ST_FIN
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       start_reg;
    logic [LOOK_W-1:0]      look_reg;
    logic [WIN_W-1:0]       win_reg;

    logic [CB-1:0]          robot_x_reg;
    logic [CB-1:0]          robot_y_reg;
    logic [CB-1:0]          cur_x_reg;
    logic [CB-1:0]          cur_y_reg;
    logic [CB-1:0]          nxt_x_reg;
    logic [CB-1:0]          nxt_y_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       scan_end_reg;
    logic                   scan_first_reg;
    logic                   walking_reg;
    logic [IDX_W-1:0]       best_reg;
    logic [DSQ_W-1:0]       best_d_reg;
    logic [DIFF_W-1:0]      dx_reg;
    logic [DIFF_W-1:0]      dy_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      acc_reg;
    logic [LOOK_W-1:0]      cum_reg;
    logic [N_W-1:0]         chunk_reg;
    logic                   trunc_reg;
    logic                   final_reg;
    logic                   pend_valid_reg;
    logic [CB-1:0]          pend_x_reg;
    logic [CB-1:0]          pend_y_reg;
    logic [IDX_W-1:0]       pend_idx_reg;
    logic                   res_valid_reg;
    wla_pkg::res_t          res_reg;

    logic                   cmd_take;
    logic                   mem_we;
    logic [IDX_W-1:0]       rd_addr;
    logic [CB-1:0]          ram_x;
    logic [CB-1:0]          ram_y;
    logic [CB-1:0]          ref_x;
    logic [CB-1:0]          ref_y;
    logic [DIFF_W-1:0]      diff_x;
    logic [DIFF_W-1:0]      diff_y;
    logic [DIFF_W-1:0]      mul_a;
    logic [PROD_W-1:0]      mul_p;
    logic [DSQ_W-1:0]       dsq_sum;
    logic                   take_best;
    logic [IDX_W-1:0]       best_new;
    logic [CNT_W-1:0]       idx_inc;
    logic [IDX_W-1:0]       scan_s;
    logic [SUM_W-1:0]       end_sum;
    logic [CNT_W-1:0]       scan_end;
    logic                   sq_start;
    logic                   sq_done;
    logic [wla_pkg::ROOT_W-1:0] sq_root;
    logic [CUM_W-1:0]       cum_next;
    logic                   out_free;
    logic                   chunk_full;
    logic [IDX_W+PIDX_W-1:0] pend_idx_ext;

    assign cmd_take = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign mem_we = cmd_take && (cmd.kind == wla_pkg::KIND_APPEND)
                    && (count_reg < CNT_W'(PATH_DEPTH));

    assign idx_inc = {1'b0, idx_reg} + CNT_W'(1);
    assign rd_addr = (state_reg == ST_WALK_RD) ? idx_inc[IDX_W-1:0] : idx_reg;

    wla_ram #(
        .WIDTH (CB),
        .DEPTH (PATH_DEPTH)
    ) u_ram_x (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (cmd.coord_x),
        .raddr (rd_addr),
        .rdata (ram_x)
    );

    wla_ram #(
        .WIDTH (CB),
        .DEPTH (PATH_DEPTH)
    ) u_ram_y (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (cmd.coord_y),
        .raddr (rd_addr),
        .rdata (ram_y)
    );

    // absolute coordinate differences against the robot or the current waypoint
    always_comb
    begin
        ref_x  = walking_reg ? cur_x_reg : robot_x_reg;
        ref_y  = walking_reg ? cur_y_reg : robot_y_reg;
        diff_x = {ram_x[CB-1], ram_x} - {ref_x[CB-1], ref_x};
        diff_y = {ram_y[CB-1], ram_y} - {ref_y[CB-1], ref_y};
        if (diff_x[DIFF_W-1])
        begin
            diff_x = -diff_x;
        end
        if (diff_y[DIFF_W-1])
        begin
            diff_y = -diff_y;
        end
    end

    // shared squaring unit
    assign mul_a   = (state_reg == ST_SQY) ? dy_reg : dx_reg;
    assign mul_p   = mul_a * mul_a;
    assign dsq_sum = DSQ_W'(acc_reg) + DSQ_W'(prod_reg);

    assign take_best = scan_first_reg || (dsq_sum < best_d_reg);
    assign best_new  = take_best ? idx_reg : best_reg;

    assign scan_s   = ({1'b0, start_reg} < count_reg) ? start_reg : '0;
    assign end_sum  = SUM_W'(scan_s) + SUM_W'(win_reg);
    assign scan_end = (end_sum > SUM_W'(count_reg)) ? count_reg : end_sum[CNT_W-1:0];

    assign sq_start = (state_reg == ST_SUM) && walking_reg;

    wla_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (dsq_sum),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign cum_next     = CUM_W'(cum_reg) + CUM_W'(sq_root);
    assign out_free     = !res_valid_reg || !res_stall;
    assign chunk_full   = (chunk_reg == N_W'(MAX_CHUNK));
    assign pend_idx_ext = {{PIDX_W{1'b0}}, pend_idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            start_reg      <= '0;
            look_reg       <= wla_pkg::LOOK_RESET;
            win_reg        <= wla_pkg::WIN_RESET;
            scan_first_reg <= 1'b0;
            walking_reg    <= 1'b0;
            chunk_reg      <= '0;
            trunc_reg      <= 1'b0;
            final_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    wla_pkg::CFG_LOOKAHEAD: look_reg <= cfg_data;
                    wla_pkg::CFG_WINDOW:    win_reg  <= cfg_data[WIN_W-1:0];
                    default:                ;
                endcase
            end

            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_take)
                    begin
                        unique case (cmd.kind)
                            wla_pkg::KIND_APPEND:
                            begin
                                if (mem_we)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            wla_pkg::KIND_CLEAR:
                            begin
                                count_reg <= '0;
                                start_reg <= '0;
                            end
                            wla_pkg::KIND_QUERY:
                            begin
                                robot_x_reg    <= cmd.coord_x;
                                robot_y_reg    <= cmd.coord_y;
                                walking_reg    <= 1'b0;
                                scan_first_reg <= 1'b1;
                                chunk_reg      <= '0;
                                cum_reg        <= '0;
                                trunc_reg      <= 1'b0;
                                idx_reg        <= scan_s;
                                best_reg       <= scan_s;
                                scan_end_reg   <= scan_end;
                                if (count_reg == '0)
                                begin
                                    state_reg <= ST_FIN;
                                end
                                else if (win_reg == '0)
                                begin
                                    start_reg <= scan_s;
                                    state_reg <= ST_WALK_START;
                                end
                                else
                                begin
                                    state_reg <= ST_SCAN_RD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN_RD:
                begin
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    dx_reg <= diff_x;
                    dy_reg <= diff_y;
                    if (walking_reg)
                    begin
                        nxt_x_reg <= ram_x;
                        nxt_y_reg <= ram_y;
                    end
                    state_reg <= ST_SQX;
                end
                ST_SQX:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQY;
                end
                ST_SQY:
                begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= mul_p;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (walking_reg)
                    begin
                        state_reg <= ST_WALK_SQRT;
                    end
                    else
                    begin
                        scan_first_reg <= 1'b0;
                        if (take_best)
                        begin
                            best_d_reg <= dsq_sum;
                        end
                        best_reg <= best_new;
                        if (idx_inc < scan_end_reg)
                        begin
                            idx_reg   <= idx_inc[IDX_W-1:0];
                            state_reg <= ST_SCAN_RD;
                        end
                        else
                        begin
                            start_reg <= best_new;
                            idx_reg   <= best_new;
                            state_reg <= ST_WALK_START;
                        end
                    end
                end
                ST_WALK_START:
                begin
                    walking_reg <= 1'b1;
                    state_reg   <= ST_WALK_CUR;
                end
                ST_WALK_CUR:
                begin
                    cur_x_reg <= ram_x;
                    cur_y_reg <= ram_y;
                    state_reg <= ST_WALK_CHK;
                end
                ST_WALK_CHK:
                begin
                    if (idx_inc >= count_reg)
                    begin
                        if (chunk_full)
                        begin
                            trunc_reg <= 1'b1;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            final_reg <= 1'b1;
                            state_reg <= ST_EMIT;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_WALK_RD;
                    end
                end
                ST_WALK_RD:
                begin
                    state_reg <= ST_DIFF;
                end
                ST_WALK_SQRT:
                begin
                    if (sq_done)
                    begin
                        state_reg <= ST_WALK_ACC;
                    end
                end
                ST_WALK_ACC:
                begin
                    if (cum_next >= CUM_W'(look_reg))
                    begin
                        state_reg <= ST_FIN;
                    end
                    else if (chunk_full)
                    begin
                        trunc_reg <= 1'b1;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        cum_reg   <= cum_next[LOOK_W-1:0];
                        final_reg <= 1'b0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    // the held point goes out only once we know it is not the final beat
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            res_valid_reg         <= 1'b1;
                            res_reg.point_x       <= pend_x_reg;
                            res_reg.point_y       <= pend_y_reg;
                            res_reg.point_index   <= pend_idx_ext[PIDX_W-1:0];
                            res_reg.valid_res     <= 1'b1;
                            res_reg.last          <= 1'b0;
                            res_reg.truncated     <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_x_reg     <= cur_x_reg;
                        pend_y_reg     <= cur_y_reg;
                        pend_idx_reg   <= idx_reg;
                        chunk_reg      <= chunk_reg + 1'b1;
                        if (final_reg)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            cur_x_reg <= nxt_x_reg;
                            cur_y_reg <= nxt_y_reg;
                            idx_reg   <= idx_inc[IDX_W-1:0];
                            state_reg <= ST_WALK_CHK;
                        end
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        res_reg.last  <= 1'b1;
                        if (pend_valid_reg)
                        begin
                            res_reg.point_x     <= pend_x_reg;
                            res_reg.point_y     <= pend_y_reg;
                            res_reg.point_index <= pend_idx_ext[PIDX_W-1:0];
                            res_reg.valid_res   <= 1'b1;
                            res_reg.truncated   <= trunc_reg;
                        end
                        else
                        begin
                            res_reg.point_x     <= '0;
                            res_reg.point_y     <= '0;
                            res_reg.point_index <= '0;
                            res_reg.valid_res   <= 1'b0;
                            res_reg.truncated   <= 1'b0;
                        end
                        pend_valid_reg <= 1'b0;
                        trunc_reg      <= 1'b0;
                        walking_reg    <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PATH_DEPTH))
        else $error("path count beyond depth");

    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_reg <= N_W'(MAX_CHUNK))
        else $error("chunk count beyond cap");

    a_sqrt_owner: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> state_reg == ST_WALK_SQRT)
        else $error("square root finished outside the walk");

    a_flags_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (!res.valid_res || res.truncated) |-> res.last)
        else $error("empty or truncated beat not marked last");
`endif

endmodule
